FILE: design/sspq_pkg.sv
`timescale 1ns / 1ps

package sspq_pkg;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_PRIO_BITS = 16;
    localparam int DEF_TAG_BITS  = 16;

    localparam int OPCODE_BITS = 2;
    localparam int STATUS_BITS = 2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_INSERT  = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic deq;
    } cell_ctl_t;

endpackage

FILE: design/sspq_cell.sv
`timescale 1ns / 1ps

module sspq_cell #(
    parameter int PRIO_BITS = 16,
    parameter int TAG_BITS  = 16
) (
    input  logic                  aclk,
    input  sspq_pkg::cell_ctl_t   ctl,
    input  logic                  occupied,
    input  logic [PRIO_BITS-1:0]  new_prio,
    input  logic [TAG_BITS-1:0]   new_tag,
    input  logic                  left_behind,
    input  logic [PRIO_BITS-1:0]  left_prio,
    input  logic [TAG_BITS-1:0]   left_tag,
    input  logic [PRIO_BITS-1:0]  right_prio,
    input  logic [TAG_BITS-1:0]   right_tag,
    output logic                  behind,
    output logic [PRIO_BITS-1:0]  prio,
    output logic [TAG_BITS-1:0]   tag
);
    import sspq_pkg::*;

    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;

    // New entry goes ahead of this cell: empty slot or strictly larger number
    assign behind = !occupied || (prio_reg > new_prio);
    assign prio   = prio_reg;
    assign tag    = tag_reg;

    always_comb begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (ctl.ins && behind) begin
            if (left_behind) begin
                // shift towards the back
                prio_next = left_prio;
                tag_next  = left_tag;
            end else begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end
        end else if (ctl.deq) begin
            // advance towards the front
            prio_next = right_prio;
            tag_next  = right_tag;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

endmodule

FILE: design/stable_sorted_priority_queue_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields in tdata (lowest bit first)
// s_        in   opcode, prio_in, tag_in
// m_        out  status, prio_out, tag_out, entry_count
//
// One request per cycle while the output is not stalled; the result is registered and appears the cycle after.
// Every cell compares the new priority with its own; each one that moves shifts in that same cycle.
// A new request is taken while the output register is empty or being drained.
// Reset empties the queue and the output register.

module stable_sorted_priority_queue_top #(
    parameter int CAPACITY  = sspq_pkg::DEF_CAPACITY,
    parameter int PRIO_BITS = sspq_pkg::DEF_PRIO_BITS,
    parameter int TAG_BITS  = sspq_pkg::DEF_TAG_BITS,
    localparam int COUNT_BITS = $clog2(CAPACITY + 1),
    localparam int S_BITS = sspq_pkg::OPCODE_BITS + PRIO_BITS + TAG_BITS,
    localparam int S_W    = ((S_BITS + 7) / 8) * 8,
    localparam int M_BITS = sspq_pkg::STATUS_BITS + PRIO_BITS + TAG_BITS + COUNT_BITS,
    localparam int M_W    = ((M_BITS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [S_W-1:0] s_tdata,   // opcode, prio_in, tag_in
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata    // status, prio_out, tag_out, entry_count
);
    import sspq_pkg::*;

    localparam int PRIO_LO = OPCODE_BITS;
    localparam int TAG_LO  = OPCODE_BITS + PRIO_BITS;

    logic                  accept;
    op_t                   op;
    logic [PRIO_BITS-1:0]  new_prio;
    logic [TAG_BITS-1:0]   new_tag;
    logic                  full, empty;
    cell_ctl_t             ctl;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  m_tvalid_reg;
    logic [M_BITS-1:0]     m_data_reg, m_data_next;

    status_t               status;
    logic [PRIO_BITS-1:0]  prio_out;
    logic [TAG_BITS-1:0]   tag_out;

    logic                  cell_behind [CAPACITY];
    logic [PRIO_BITS-1:0]  cell_prio   [CAPACITY];
    logic [TAG_BITS-1:0]   cell_tag    [CAPACITY];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign op       = op_t'(s_tdata[OPCODE_BITS-1:0]);
    assign new_prio = s_tdata[PRIO_LO +: PRIO_BITS];
    assign new_tag  = s_tdata[TAG_LO +: TAG_BITS];

    assign full  = (count_reg == COUNT_BITS'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb begin
        ctl        = '0;
        status     = ST_OK;
        prio_out   = '0;
        tag_out    = '0;
        count_next = count_reg;
        unique case (op)
            OP_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctl.ins    = accept;
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    prio_out = cell_prio[0];
                    tag_out  = cell_tag[0];
                    if (op == OP_DEQUEUE) begin
                        ctl.deq    = accept;
                        count_next = count_reg - COUNT_BITS'(1);
                    end
                end
            end
            default: begin
                // unused opcode: leave the queue untouched
            end
        endcase
        m_data_next = {count_next, tag_out, prio_out, status};
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic                 left_behind;
            logic [PRIO_BITS-1:0] left_prio, right_prio;
            logic [TAG_BITS-1:0]  left_tag, right_tag;

            if (i == 0) begin : g_head
                assign left_behind = 1'b0;
                assign left_prio   = new_prio;
                assign left_tag    = new_tag;
            end else begin : g_body
                assign left_behind = cell_behind[i-1];
                assign left_prio   = cell_prio[i-1];
                assign left_tag    = cell_tag[i-1];
            end

            if (i == CAPACITY - 1) begin : g_tail
                assign right_prio = '0;
                assign right_tag  = '0;
            end else begin : g_inner
                assign right_prio = cell_prio[i+1];
                assign right_tag  = cell_tag[i+1];
            end

            sspq_cell #(
                .PRIO_BITS (PRIO_BITS),
                .TAG_BITS  (TAG_BITS)
            ) u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .occupied    (COUNT_BITS'(i) < count_reg),
                .new_prio    (new_prio),
                .new_tag     (new_tag),
                .left_behind (left_behind),
                .left_prio   (left_prio),
                .left_tag    (left_tag),
                .right_prio  (right_prio),
                .right_tag   (right_tag),
                .behind      (cell_behind[i]),
                .prio        (cell_prio[i]),
                .tag         (cell_tag[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_W - M_BITS){1'b0}}, m_data_reg};

endmodule
